@@ design/lups_pkg.sv @@
// Shared types, constants and helpers of the least-used port selector.
`timescale 1ns / 1ps

package lups_pkg;

  // Fixed field widths of the request and result payloads.
  localparam int ROUTER_ID_W   = 6;
  localparam int VALID_PORTS_W = 8;
  localparam int SEL_PORT_W    = 3;

  // Defaults of the top-level parameters.
  localparam int NUM_ROUTERS_DEF = 64;
  localparam int NUM_PORTS_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 32;

  // Tie-break LFSR.
  localparam int              LFSR_W     = 16;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

  // Remainder unit: dividend bits retired per cycle and the resulting step count.
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = LFSR_W / DIV_BITS;

  typedef struct packed {
    logic [ROUTER_ID_W-1:0]   router_id;
    logic [VALID_PORTS_W-1:0] valid_ports;
  } lups_in_t;

  typedef struct packed {
    logic [SEL_PORT_W-1:0] sel_port;
    logic                  no_valid_port;
  } lups_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } lups_state_e;

  // Galois LFSR, shifting right.
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

@@ design/least_used_port_selector_top.sv @@
// Top level of the least-used output port selector with random tie-break.
`timescale 1ns / 1ps

// Usage:
// A request (router_id, valid_ports) is taken on the in channel when in_valid_i and
// in_ready_o are both high. Exactly one result (sel_port, no_valid_port) leaves
// on the out channel per request, in request order.
// The per-router row of port counts sits in one RAM row; a request reads the row,
// scans every port one per cycle, counting only the admissible ones, for the minimum
// count and the set of tied ports, reduces the LFSR value modulo the tie count (4 bits
// per cycle), then writes the incremented row back; an empty mask skips the last two.
// One request is in flight at a time, so a new request is taken only after the
// previous one has left the done state.
// A finished result waits in an output register, so the next request may be taken
// while the receiver stalls; the following result waits until that register frees.
// After reset the count RAM is cleared one row per cycle, all NUM_ROUTERS rows, while
// in_ready_o stays low. The seed register is always writable and reloads the LFSR.
module least_used_port_selector_top import lups_pkg::*; #(
  parameter int NUM_ROUTERS = NUM_ROUTERS_DEF,
  parameter int NUM_PORTS   = NUM_PORTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lups_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lups_out_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LFSR_W-1:0] cfg_data_i
);

  localparam int AddrW    = (NUM_ROUTERS > 1) ? $clog2(NUM_ROUTERS) : 1;
  localparam int PortIdxW = $clog2(NUM_PORTS);
  localparam int CntW     = $clog2(NUM_PORTS + 1);
  localparam int RowW     = NUM_PORTS * COUNT_WIDTH;
  localparam int ModW     = ROUTER_ID_W + 1;
  localparam int IdSpan   = 1 << ROUTER_ID_W;
  localparam logic [ModW-1:0] NrClip =
      ModW'((NUM_ROUTERS >= IdSpan) ? IdSpan : NUM_ROUTERS);

  lups_state_e          state_q, state_d;
  logic [LFSR_W-1:0]    lfsr_q, lfsr_d;
  logic [AddrW-1:0]     clr_q, clr_d;
  logic [AddrW-1:0]     addr_q;
  logic [NUM_PORTS-1:0] mask_q;
  logic [LFSR_W-1:0]    rnd_q;
  logic [PortIdxW-1:0]  port_q, port_d;
  logic                 found_q, found_d;
  logic [COUNT_WIDTH-1:0] best_q, best_d;
  logic [NUM_PORTS-1:0] tie_q, tie_d;
  logic [CntW-1:0]      ntied_q, ntied_d;
  logic                 out_valid_q, out_valid_d;
  lups_out_t            out_q;

  logic                 in_fire, cfg_fire, out_free, done_fire;
  logic [ModW-1:0]      rid_rem;
  logic [AddrW-1:0]     rd_addr;
  logic [RowW-1:0]      row_rd, row_wr;
  logic [COUNT_WIDTH-1:0] cur, cur_sel;
  logic [NUM_PORTS-1:0] onehot;
  logic                 take_new, tie_eq;
  logic [PortIdxW-1:0]  chosen;
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr;
  logic [RowW-1:0]      mem_wdata;
  logic                 div_start, div_done;
  logic [CntW-1:0]      div_rem;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign done_fire   = (state_q == ST_DONE) && out_free;

  // Router index wraps modulo NUM_ROUTERS; reduced combinationally, bit by bit, on the 6-bit id.
  always_comb begin
    rid_rem = '0;
    for (int i = 0; i < ROUTER_ID_W; i++) begin
      rid_rem = {rid_rem[ModW-2:0], in_data_i.router_id[ROUTER_ID_W-1-i]};
      if (rid_rem >= NrClip) begin
        rid_rem = rid_rem - NrClip;
      end
    end
  end
  assign rd_addr = AddrW'(rid_rem);

  // One port of the row per scan cycle: track the minimum and the tied set.
  assign cur      = row_rd[port_q*COUNT_WIDTH +: COUNT_WIDTH];
  assign onehot   = NUM_PORTS'(1) << port_q;
  assign take_new = mask_q[port_q] && (!found_q || (cur < best_q));
  assign tie_eq   = mask_q[port_q] && found_q && (cur == best_q);

  // Pick the tied port whose rank among the tied ports equals the remainder.
  always_comb begin
    logic [NUM_PORTS-1:0] low;
    logic [CntW-1:0]      pre;
    chosen = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      low = (NUM_PORTS'(1) << p) - NUM_PORTS'(1);
      pre = CntW'($countones(tie_q & low));
      if (tie_q[p] && (pre == div_rem)) begin
        chosen = chosen | PortIdxW'(p);
      end
    end
  end

  always_comb begin
    row_wr  = row_rd;
    cur_sel = row_rd[chosen*COUNT_WIDTH +: COUNT_WIDTH];
    row_wr[chosen*COUNT_WIDTH +: COUNT_WIDTH] =
        (&cur_sel) ? cur_sel : cur_sel + COUNT_WIDTH'(1);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    port_d      = port_q;
    found_d     = found_q;
    best_d      = best_q;
    tie_d       = tie_q;
    ntied_d     = ntied_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = row_wr;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(NUM_ROUTERS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          port_d  = '0;
          found_d = 1'b0;
          tie_d   = '0;
          ntied_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        found_d = found_q || mask_q[port_q];
        if (take_new) begin
          best_d  = cur;
          tie_d   = onehot;
          ntied_d = CntW'(1);
        end else if (tie_eq) begin
          tie_d   = tie_q | onehot;
          ntied_d = ntied_q + CntW'(1);
        end
        port_d = port_q + PortIdxW'(1);
        if (port_q == PortIdxW'(NUM_PORTS - 1)) begin
          if (found_d) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          mem_we      = found_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    lfsr_d = lfsr_q;
    if (cfg_fire) begin
      lfsr_d = (cfg_data_i == '0) ? LFSR_W'(1) : cfg_data_i;
    end else if (in_fire) begin
      lfsr_d = lfsr_next(lfsr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      lfsr_q      <= SEED_RESET;
      clr_q       <= '0;
      port_q      <= '0;
      found_q     <= 1'b0;
      tie_q       <= '0;
      ntied_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lfsr_q      <= lfsr_d;
      clr_q       <= clr_d;
      port_q      <= port_d;
      found_q     <= found_d;
      tie_q       <= tie_d;
      ntied_q     <= ntied_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    if (in_fire) begin
      addr_q <= rd_addr;
      mask_q <= NUM_PORTS'(in_data_i.valid_ports);
      rnd_q  <= lfsr_q;
    end
    if (done_fire) begin
      out_q.sel_port      <= found_q ? SEL_PORT_W'(chosen) : '0;
      out_q.no_valid_port <= !found_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  lups_ram #(
    .WIDTH(RowW),
    .DEPTH(NUM_ROUTERS)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (in_fire),
    .raddr_i(rd_addr),
    .rdata_o(row_rd)
  );

  lups_div #(
    .NUM_PORTS(NUM_PORTS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(rnd_q),
    .divisor_i (ntied_d),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  // An accepted request always starts a row scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_SCAN))
    else $error("request transfer did not start a scan");

  // The remainder unit finishes only while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("remainder done outside the divide state");

  // The tie counter matches the tied-port set while the remainder is formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (ntied_q == CntW'($countones(tie_q))))
    else $error("tie count disagrees with tied-port set");

  // A new result appears only out of the final state of a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the done state");

endmodule

@@ design/lups_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lups_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lups_div.sv @@
// Iterative remainder unit: 16-bit dividend modulo a small nonzero divisor.
`timescale 1ns / 1ps

module lups_div import lups_pkg::*; #(
  parameter int NUM_PORTS = NUM_PORTS_DEF,
  localparam int CntW = $clog2(NUM_PORTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LFSR_W-1:0] dividend_i,
  input  logic [CntW-1:0]   divisor_i,
  output logic              done_o,
  output logic [CntW-1:0]   rem_o
);

  localparam int StepW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [LFSR_W-1:0] dvd_q;
  logic [CntW-1:0]   dsr_q;
  logic [CntW-1:0]   rem_q;
  logic [CntW-1:0]   rem_v;

  // Restoring remainder, DIV_BITS dividend bits per cycle. The partial
  // remainder stays below the divisor, so one conditional subtract per bit.
  always_comb begin
    logic [CntW:0] t;
    rem_v = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {rem_v, dvd_q[LFSR_W-1-i]};
      if (t >= {1'b0, dsr_q}) begin
        t = t - {1'b0, dsr_q};
      end
      rem_v = t[CntW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << DIV_BITS;
      rem_q <= rem_v;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
